// ===== rtl/core/tcpq_pkg.sv =====
// package for the two-class priority queue
// holds command and status codes, cell control structs and parameter defaults
// no dependencies
package tcpq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int ID_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        CMD_INSERT     = 2'd0,
        CMD_SERVE_PREF = 2'd1,
        CMD_SERVE_OLD  = 2'd2,
        CMD_WITHDRAW   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ID    = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // broadcast to every cell, already qualified by the status checks
    typedef struct packed {
        logic insert;
        logic ins_pref;
        logic withdraw;
        logic serve_pref;
        logic serve_old;
        logic any_pref;
    } t_cell_ctl;

    // handed from the head side to the tail side along the row
    typedef struct packed {
        logic rm;   // an entry nearer the head is removed
        logic pf;   // a preferential entry lies nearer the head
        logic vld;  // the cell nearer the head holds an entry
    } t_chain;

endpackage

// ===== rtl/core/tcpq_if.sv =====
// item channels of the two-class priority queue
// command channel and response channel, valid/ready handshake
// depends on nothing but the parameters given at instantiation
interface tcpq_cmd_if #(
    parameter int ID_WIDTH = 16
);
    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic signed [ID_WIDTH-1:0] id;
    logic                       preferential;

    modport source (output valid, output cmd, output id, output preferential, input ready);
    modport sink (input valid, input cmd, input id, input preferential, output ready);
endinterface

interface tcpq_rsp_if #(
    parameter int ID_WIDTH = 16,
    parameter int CNT_W    = 5
);
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic [ID_WIDTH-2:0] served_id;
    logic [CNT_W-1:0]    total_count;
    logic [CNT_W-1:0]    preferred_count;

    modport source (output valid, output status, output served_id, output total_count,
                    output preferred_count, input ready);
    modport sink (input valid, input status, input served_id, input total_count,
                  input preferred_count, output ready);
endinterface

// ===== rtl/core/tcpq_cell.sv =====
// one queue slot of the two-class priority queue
// holds one id with its class flag, compares, selects and shifts toward the head
// depends on tcpq_pkg
module tcpq_cell import tcpq_pkg::*; #(
    parameter int ID_WIDTH = ID_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [ID_WIDTH-2:0] i_key,
    input  logic                i_head,
    input  t_chain              i_up,
    output t_chain              o_dn,
    input  logic                i_nxt_vld,
    input  logic                i_nxt_pref,
    input  logic [ID_WIDTH-2:0] i_nxt_id,
    output logic                o_vld,
    output logic                o_pref,
    output logic [ID_WIDTH-2:0] o_id,
    output logic                o_match,
    output logic                o_sel
);

    logic                r_vld, n_vld;
    logic                r_pref, n_pref;
    logic [ID_WIDTH-2:0] r_id, n_id;
    logic                pick_pref;
    logic                shift;
    logic                ins_here;

    assign o_match = r_vld && (r_id == i_key);

    // oldest preferential entry, or the head when no entry is preferential
    assign pick_pref = i_ctl.any_pref ? (r_pref && !i_up.pf) : i_head;

    assign o_sel = r_vld && ((i_ctl.withdraw && o_match) ||
                             (i_ctl.serve_old && i_head) ||
                             (i_ctl.serve_pref && pick_pref));

    assign shift    = i_up.rm || o_sel;
    assign ins_here = i_ctl.insert && !r_vld && i_up.vld;

    assign o_dn.rm  = shift;
    assign o_dn.pf  = i_up.pf || (r_vld && r_pref);
    assign o_dn.vld = r_vld;

    always_comb begin
        n_vld  = r_vld;
        n_pref = r_pref;
        n_id   = r_id;
        if (shift) begin
            n_vld  = i_nxt_vld;
            n_pref = i_nxt_pref;
            n_id   = i_nxt_id;
        end else if (ins_here) begin
            n_vld  = 1'b1;
            n_pref = i_ctl.ins_pref;
            n_id   = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_pref <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_pref <= n_pref;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_vld  = r_vld;
    assign o_pref = r_pref;
    assign o_id   = r_id;

endmodule

// ===== rtl/core/two_class_priority_queue.sv =====
// the response item is registered and valid in the cycle after its command is accepted
// throughput: one command per cycle while responses are taken; the response register frees as it is taken
// the row of cells compares, selects and shifts in the same cycle the command is taken
// reset (synchronous, active low) empties the queue and clears both counts
// top level of the two-class priority queue, depends on tcpq_pkg, tcpq_if, tcpq_cell
module two_class_priority_queue import tcpq_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int ID_WIDTH = ID_WIDTH_DEF,
    parameter int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcpq_cmd_if.sink   i_cmd,
    tcpq_rsp_if.source o_rsp
);

    // per-cell views of the row
    logic [DEPTH-1:0]    cell_vld;
    logic [DEPTH-1:0]    cell_pref;
    logic [ID_WIDTH-2:0] cell_id [DEPTH];
    logic [DEPTH-1:0]    cell_match;
    logic [DEPTH-1:0]    cell_sel;
    t_chain              chain [DEPTH+1];

    // registered counts, kept in step with the row
    logic [CNT_W-1:0]    r_total, n_total;
    logic [CNT_W-1:0]    r_prefs, n_prefs;

    // response register
    logic                r_out_vld;
    t_status             r_status, n_status;
    logic [ID_WIDTH-2:0] r_served, n_served;

    t_cmd                cmd;
    logic                accept;
    logic                id_neg;
    logic [ID_WIDTH-2:0] key;
    logic                found;
    logic                rm_pref;
    logic [ID_WIDTH-2:0] sel_id;
    t_cell_ctl           ctl;

    assign cmd    = t_cmd'(i_cmd.cmd);
    assign id_neg = i_cmd.id[ID_WIDTH-1];
    assign key    = i_cmd.id[ID_WIDTH-2:0];

    // a new command enters whenever the response register is free or being taken
    assign i_cmd.ready = !r_out_vld || o_rsp.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // ids are unique, so at most one cell matches and at most one is selected
    always_comb begin
        found   = 1'b0;
        rm_pref = 1'b0;
        sel_id  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            found   = found | cell_match[i];
            rm_pref = rm_pref | (cell_sel[i] & cell_pref[i]);
            sel_id  = sel_id | (cell_id[i] & {(ID_WIDTH-1){cell_sel[i]}});
        end
    end

    // status checks and qualified control for the row
    always_comb begin
        ctl          = '0;
        ctl.ins_pref = i_cmd.preferential;
        ctl.any_pref = (r_prefs != '0);
        n_status     = ST_OK;
        unique case (cmd)
            CMD_INSERT: begin
                if (id_neg || found) begin
                    n_status = ST_BAD_ID;
                end else if (r_total == CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.insert = accept;
                end
            end
            CMD_SERVE_PREF: begin
                if (r_total == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctl.serve_pref = accept;
                end
            end
            CMD_SERVE_OLD: begin
                if (r_total == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctl.serve_old = accept;
                end
            end
            CMD_WITHDRAW: begin
                if (id_neg || !found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    ctl.withdraw = accept;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    // served id is reported only for a serve command that removed an entry
    assign n_served = (ctl.serve_pref || ctl.serve_old) ? sel_id : '0;

    // counts after this command
    always_comb begin
        n_total = r_total;
        n_prefs = r_prefs;
        if (ctl.insert) begin
            n_total = r_total + CNT_W'(1);
            n_prefs = r_prefs + CNT_W'(i_cmd.preferential);
        end else if (ctl.serve_pref || ctl.serve_old || ctl.withdraw) begin
            n_total = r_total - CNT_W'(1);
            n_prefs = r_prefs - CNT_W'(rm_pref);
        end
    end

    // head of the row: nothing removed ahead, no preferential ahead, tail slot open
    assign chain[0] = '{rm: 1'b0, pf: 1'b0, vld: 1'b1};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                nxt_vld;
        logic                nxt_pref;
        logic [ID_WIDTH-2:0] nxt_id;

        // last cell pulls in an empty slot when the row shifts
        if (g == DEPTH - 1) begin : g_tail
            assign nxt_vld  = 1'b0;
            assign nxt_pref = 1'b0;
            assign nxt_id   = '0;
        end else begin : g_mid
            assign nxt_vld  = cell_vld[g+1];
            assign nxt_pref = cell_pref[g+1];
            assign nxt_id   = cell_id[g+1];
        end

        tcpq_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_key      (key),
            .i_head     (g == 0),
            .i_up       (chain[g]),
            .o_dn       (chain[g+1]),
            .i_nxt_vld  (nxt_vld),
            .i_nxt_pref (nxt_pref),
            .i_nxt_id   (nxt_id),
            .o_vld      (cell_vld[g]),
            .o_pref     (cell_pref[g]),
            .o_id       (cell_id[g]),
            .o_match    (cell_match[g]),
            .o_sel      (cell_sel[g])
        );
    end

    // control state: counts and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_prefs   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_total <= n_total;
            r_prefs <= n_prefs;
            if (accept) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // response payload, loaded with each accepted command
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_served <= n_served;
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.status          = r_status;
    assign o_rsp.served_id       = r_served;
    assign o_rsp.total_count     = r_total;
    assign o_rsp.preferred_count = r_prefs;

endmodule
